### sv/bmsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the bank mapper with scanline interrupt.
// Depends on nothing; imported by bank_mapper_scanline_irq.

package bmsi_pkg;

  // Item kind carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_REG_WRITE = 2'd0,
    KIND_PPU_ADDR  = 2'd1,
    KIND_PRG_XLATE = 2'd2
  } kind_e;

  // Register decode key: {cpu_addr[15:13], cpu_addr[0]}.
  typedef enum logic [3:0] {
    REG_BANK_SELECT = 4'b1000,
    REG_BANK_DATA   = 4'b1001,
    REG_MIRROR      = 4'b1010,
    REG_IRQ_VALUE   = 4'b1100,
    REG_IRQ_RELOAD  = 4'b1101,
    REG_IRQ_DISABLE = 4'b1110,
    REG_IRQ_ENABLE  = 4'b1111
  } reg_sel_e;

  // Configuration register indexes.
  localparam logic CFG_PRG_PAGE_COUNT = 1'b0;
  localparam logic CFG_CHR_PAGE_COUNT = 1'b1;

  localparam logic [6:0] PRG_PAGE_COUNT_RST = 7'd64;
  localparam logic [8:0] CHR_PAGE_COUNT_RST = 9'd256;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

endpackage

`default_nettype wire

### sv/bank_mapper_scanline_irq.sv
`timescale 1ns / 1ps
`default_nettype none
// Bank mapper with a scanline interrupt counter: register decode, A12 edge
// filter, IRQ counter and CHR/PRG page translation. Uses bmsi_pkg.
//
// Usage:
//   Input stream (s_axis_*): one beat per item. tuser carries the kind
//   (register write, PPU address seen, CPU program translate); tdata carries
//   cpu_addr, data and ppu_addr. Output stream (m_axis_*): exactly one beat
//   per input beat, in order, carrying prg_page, chr_page, the current
//   mirroring bit and the IRQ pending flag.
//   A beat taken sits in the input register, and its result then lands in
//   the output register, from which the receiver takes it.
//   Throughput is one beat per cycle while the receiver does not stall; all
//   work on a beat is one pass of short logic between the input register
//   and the output register.
//   When the receiver stalls, the result waits in the output register and one
//   more beat is held in the input register; tready then falls.
//   The configuration port (cfg_we_i, cfg_addr_i, cfg_data_i) sets the PRG
//   and CHR page counts; write it only while no beat is in flight.
//   Reset clears all mapper state, sets the page counts to 64 and 256 and
//   empties both registers; no clearing pass is needed.

module bank_mapper_scanline_irq
  import bmsi_pkg::*;
#(
  parameter int unsigned A12_LOW_FILTER = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port.
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_addr_i,
  input  wire logic [8:0]            cfg_data_i,
  // Input stream.
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: cpu_addr[15:0], data[23:16], ppu_addr[37:24], zero pad[39:38]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind[1:0]
  input  wire logic [1:0]            s_axis_tuser_i,
  // Output stream.
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // tdata: prg_page[5:0], chr_page[13:6], mirror_horizontal[14], irq_pending[15]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam logic [3:0] FilterCount = 4'(A12_LOW_FILTER);

  // Input register.
  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_kind_q;
  logic [15:0] in_cpu_q;
  logic [7:0]  in_data_q;
  logic [13:0] in_ppu_q;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Configuration.
  logic [6:0] prg_count_q;
  logic [8:0] chr_count_q;

  // Mapper state.
  logic       prg_swap_q, prg_swap_d;
  logic       chr_inv_q, chr_inv_d;
  logic [2:0] bank_sel_q, bank_sel_d;
  logic [7:0] bank_q [8];
  logic       bank_we;
  logic [7:0] bank_wdata;
  logic       mirror_q, mirror_d;
  logic [7:0] irq_reload_q, irq_reload_d;
  logic [7:0] irq_count_q, irq_count_d;
  logic       reload_q, reload_d;
  logic       irq_en_q, irq_en_d;
  logic       prev_a12_q, prev_a12_d;
  logic [3:0] low_run_q, low_run_d;
  logic       irq_flag_q, irq_flag_d;

  logic adv;
  logic accept;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Per-beat work: register decode, A12 filter and page lookup.
  always_comb begin
    logic [3:0] key;
    logic [7:0] v;
    logic [8:0] chr_mask;
    logic       a12;
    logic       is_chr;
    logic       is_prg;
    logic [2:0] chr_slot;
    logic [1:0] prg_slot;
    logic [2:0] rd_idx;
    logic [7:0] rd_bank;
    logic [5:0] fixed_lo;
    logic [5:0] fixed_hi;
    logic [5:0] prg;
    logic [7:0] chr;

    prg_swap_d   = prg_swap_q;
    chr_inv_d    = chr_inv_q;
    bank_sel_d   = bank_sel_q;
    bank_we      = 1'b0;
    mirror_d     = mirror_q;
    irq_reload_d = irq_reload_q;
    irq_count_d  = irq_count_q;
    reload_d     = reload_q;
    irq_en_d     = irq_en_q;
    prev_a12_d   = prev_a12_q;
    low_run_d    = low_run_q;
    irq_flag_d   = irq_flag_q;

    key      = {in_cpu_q[15:13], in_cpu_q[0]};
    chr_mask = chr_count_q - 9'd1;
    v        = in_data_q;
    if (bank_sel_q <= 3'd1) begin
      v[0] = 1'b0;
    end
    if (bank_sel_q >= 3'd6) begin
      v = v & 8'h3F;
    end else begin
      v = v & chr_mask[7:0];
    end
    bank_wdata = v;

    is_chr = (in_kind_q == KIND_PPU_ADDR) && !in_ppu_q[13];
    is_prg = (in_kind_q == KIND_PRG_XLATE) && in_cpu_q[15];
    a12    = in_ppu_q[12];

    if (adv && in_kind_q == KIND_REG_WRITE) begin
      unique case (reg_sel_e'(key))
        REG_BANK_SELECT: begin
          prg_swap_d = in_data_q[6];
          chr_inv_d  = in_data_q[7];
          bank_sel_d = in_data_q[2:0];
        end
        REG_BANK_DATA:   bank_we      = 1'b1;
        REG_MIRROR:      mirror_d     = in_data_q[0];
        REG_IRQ_VALUE:   irq_reload_d = in_data_q;
        REG_IRQ_RELOAD:  reload_d     = 1'b1;
        REG_IRQ_DISABLE: begin
          irq_en_d   = 1'b0;
          irq_flag_d = 1'b0;
        end
        REG_IRQ_ENABLE:  irq_en_d     = 1'b1;
        default: ;
      endcase
    end

    if (adv && is_chr) begin
      if (!a12) begin
        if (low_run_q < FilterCount) begin
          low_run_d = low_run_q + 4'd1;
        end
      end else begin
        // A filtered rising edge clocks the scanline counter.
        if (!prev_a12_q && low_run_q >= FilterCount) begin
          if (irq_count_q == 8'd0 || reload_q) begin
            irq_count_d = irq_reload_q;
            reload_d    = 1'b0;
          end else begin
            irq_count_d = irq_count_q - 8'd1;
          end
          if (irq_count_d == 8'd0 && irq_en_q) begin
            irq_flag_d = 1'b1;
          end
        end
        low_run_d = 4'd0;
      end
      prev_a12_d = a12;
    end

    // One bank register read per beat, chosen by the kind.
    chr_slot = in_ppu_q[12:10] ^ {chr_inv_q, 2'b00};
    prg_slot = in_cpu_q[14:13];
    if (in_kind_q == KIND_PPU_ADDR) begin
      rd_idx = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
    end else begin
      rd_idx = (prg_slot == 2'd1) ? 3'd7 : 3'd6;
    end
    rd_bank = bank_q[rd_idx];

    chr = 8'd0;
    if (is_chr) begin
      chr = rd_bank + {7'd0, !chr_slot[2] && chr_slot[0]};
    end

    fixed_lo = prg_count_q[5:0] - 6'd2;
    fixed_hi = prg_count_q[5:0] - 6'd1;
    prg      = 6'd0;
    if (is_prg) begin
      unique case (prg_slot)
        2'd0:    prg = prg_swap_q ? fixed_lo : rd_bank[5:0];
        2'd1:    prg = rd_bank[5:0];
        2'd2:    prg = prg_swap_q ? rd_bank[5:0] : fixed_lo;
        default: prg = fixed_hi;
      endcase
    end

    out_data_d = {irq_flag_d, mirror_d, chr, prg};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      prg_count_q  <= PRG_PAGE_COUNT_RST;
      chr_count_q  <= CHR_PAGE_COUNT_RST;
      prg_swap_q   <= 1'b0;
      chr_inv_q    <= 1'b0;
      bank_sel_q   <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        bank_q[i] <= 8'd0;
      end
      mirror_q     <= 1'b0;
      irq_reload_q <= 8'd0;
      irq_count_q  <= 8'd0;
      reload_q     <= 1'b0;
      irq_en_q     <= 1'b0;
      prev_a12_q   <= 1'b0;
      low_run_q    <= 4'd0;
      irq_flag_q   <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_PRG_PAGE_COUNT) begin
          prg_count_q <= cfg_data_i[6:0];
        end else begin
          chr_count_q <= cfg_data_i;
        end
      end
      prg_swap_q   <= prg_swap_d;
      chr_inv_q    <= chr_inv_d;
      bank_sel_q   <= bank_sel_d;
      if (bank_we) begin
        bank_q[bank_sel_q] <= bank_wdata;
      end
      mirror_q     <= mirror_d;
      irq_reload_q <= irq_reload_d;
      irq_count_q  <= irq_count_d;
      reload_q     <= reload_d;
      irq_en_q     <= irq_en_d;
      prev_a12_q   <= prev_a12_d;
      low_run_q    <= low_run_d;
      irq_flag_q   <= irq_flag_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= s_axis_tuser_i;
      in_cpu_q  <= s_axis_tdata_i[15:0];
      in_data_q <= s_axis_tdata_i[23:16];
      in_ppu_q  <= s_axis_tdata_i[37:24];
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  function automatic logic key_is_disable();
    return reg_sel_e'({in_cpu_q[15:13], in_cpu_q[0]}) == REG_IRQ_DISABLE;
  endfunction

  // The low-sample run never climbs past the filter count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_run_q <= FilterCount)
    else $error("A12 low run exceeds filter count");

  // The counter moves only when a beat is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(irq_count_q))
    else $error("IRQ counter changed without a beat");

  // A disable write always leaves the request line low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_kind_q == KIND_REG_WRITE && key_is_disable()) |=> !irq_flag_q)
    else $error("IRQ pending after disable");

  // The request line only rises while the interrupt is enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_flag_q) |-> irq_en_q)
    else $error("IRQ raised while disabled");

  // A result beat is produced only for a beat taken from the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_q && !m_axis_tready_i) |=> (out_valid_q == $past(out_valid_q)))
    else $error("Output valid changed without a beat");

endmodule

`default_nettype wire
